[rtl/core/assert_macros.svh]
// Assertion macros shared by the touch front end modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/tcds_pkg.sv]
// Types and constants of the touch calibrate, debounce and smooth block.
package tcds_pkg;

    localparam int POS_MAX    = 16383;
    localparam int AVG_WEIGHT = 9;
    localparam int CAL_BASE   = 128;
    localparam int CAL_GAIN   = 768;
    localparam int SCALE_DIV  = 1023;
    localparam int CELL_DIV   = 16'h3FFF;
    localparam int CELL_MAX   = 255;

    localparam int DIV_W   = 42;
    localparam int DEN_W   = 16;
    localparam int CNT_W   = 6;

    typedef enum logic [2:0] {
        REG_CAL_X_LOW,
        REG_CAL_Y_LOW,
        REG_CAL_X_HIGH,
        REG_CAL_Y_HIGH,
        REG_DEBOUNCE,
        REG_TAP_WINDOW,
        REG_SCREEN_COLS,
        REG_SCREEN_ROWS
    } t_reg_idx;

    typedef struct packed {
        logic [13:0] cal_x_low;
        logic [13:0] cal_y_low;
        logic [13:0] cal_x_high;
        logic [13:0] cal_y_high;
        logic [15:0] debounce_ms;
        logic [15:0] tap_window_ms;
        logic [7:0]  screen_cols;
        logic [7:0]  screen_rows;
    } t_cfg;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALX,
        ST_SCLX,
        ST_CALY,
        ST_SCLY,
        ST_DECIDE,
        ST_SMX,
        ST_SMY,
        ST_CELX,
        ST_CELY,
        ST_OUT
    } t_state;

endpackage

[rtl/core/tcds_cfg.sv]
// Configuration register file of the touch front end.
module tcds_cfg
    import tcds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_valid,
    input  logic [2:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (t_reg_idx'(i_wr_index))
                REG_CAL_X_LOW:   n_cfg.cal_x_low     = i_wr_data[13:0];
                REG_CAL_Y_LOW:   n_cfg.cal_y_low     = i_wr_data[13:0];
                REG_CAL_X_HIGH:  n_cfg.cal_x_high    = i_wr_data[13:0];
                REG_CAL_Y_HIGH:  n_cfg.cal_y_high    = i_wr_data[13:0];
                REG_DEBOUNCE:    n_cfg.debounce_ms   = i_wr_data;
                REG_TAP_WINDOW:  n_cfg.tap_window_ms = i_wr_data;
                REG_SCREEN_COLS: n_cfg.screen_cols   = i_wr_data[7:0];
                REG_SCREEN_ROWS: n_cfg.screen_rows   = i_wr_data[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_x_low     <= 14'd128;
            r_cfg.cal_y_low     <= 14'd128;
            r_cfg.cal_x_high    <= 14'd896;
            r_cfg.cal_y_high    <= 14'd896;
            r_cfg.debounce_ms   <= 16'd100;
            r_cfg.tap_window_ms <= 16'd250;
            r_cfg.screen_cols   <= 8'd80;
            r_cfg.screen_rows   <= 8'd25;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/tcds_div.sv]
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
`include "assert_macros.svh"
module tcds_div
    import tcds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_d, n_d;
    logic             r_neg, n_neg;
    logic             r_zero, n_zero;
    logic [DEN_W-1:0] trial;
    logic             qbit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_neg  = r_neg;
        n_zero = r_zero;
        // remainder stays below the divisor, so its top bit is free
        trial  = {r_rem[DEN_W-2:0], r_q[DIV_W-1]};
        qbit   = (trial >= r_d);
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_req.num[DIV_W-1] ? DIV_W'(-i_req.num) : DIV_W'(i_req.num);
            n_d    = i_req.den[DEN_W-1] ? DEN_W'(-i_req.den) : DEN_W'(i_req.den);
            n_neg  = i_req.num[DIV_W-1] ^ i_req.den[DEN_W-1];
            n_zero = (i_req.den == '0);
        end else if (r_busy) begin
            n_rem = qbit ? (trial - r_d) : trial;
            n_q   = {r_q[DIV_W-2:0], qbit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_zero ? '0 : (r_neg ? $signed(-r_q) : $signed(r_q));

    `ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, r_busy, !i_req.start)
    `ASSERT_IMPL(a_done_after_run, i_clk, i_rst_n, r_done, $past(r_busy))

endmodule

[rtl/core/touch_calibrate_debounce_smooth_unit.sv]
// Touch front end: calibration, tap and bounce timing, smoothing, cell conversion.
//
// Input items arrive on the s_axis channel: tuser carries the report kind
// (0 finger-up, 1 position), tdata carries raw_x, raw_y and time_ms.
// Every input item gives exactly one result item on the m_axis channel:
// left_button, smoothed pos_x/pos_y and the text cell column and row.
// Registers are written over the cfg channel (index 0..7), which is always
// ready; write them only while the block is idle.
// Items are handled one at a time. All divisions go through one shared
// bit-serial divider. From accept to result valid, a finger-up item takes
// two divisions, a tap press six and any other position eight; the next
// item is taken the cycle after the result is handed to the output register.
// The result sits in an output register; the next item is accepted while it
// waits, and the block holds only when a new result finds the register
// still full. Reset restores the register defaults and clears all tracking
// state (average, offsets, release flag, drag flag, lift time).
`include "assert_macros.svh"
module touch_calibrate_debounce_smooth_unit
    import tcds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // raw_x[13:0], raw_y[27:14], time_ms[59:28], zero pad
    input  logic        i_s_axis_tuser,  // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // left_button[0], pos_x[16:1], pos_y[32:17], cell_col[41:33], cell_row[50:42], zero pad
    output logic [55:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    tcds_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    tcds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_cfg_ready = 1'b1;

    function automatic logic signed [15:0] sat16(input logic signed [DIV_W-1:0] v);
        if (v < -42'sd32768)     return -16'sd32768;
        else if (v > 42'sd32767) return 16'sd32767;
        else                     return v[15:0];
    endfunction

    function automatic logic signed [17:0] clamp_pos(input logic signed [DIV_W-1:0] v);
        if (v < 0)                     return '0;
        else if (v > DIV_W'(POS_MAX))  return 18'(POS_MAX);
        else                           return v[17:0];
    endfunction

    function automatic logic signed [8:0] sat_cell(input logic signed [DIV_W-1:0] v);
        if (v < -DIV_W'(CELL_MAX))     return -9'(CELL_MAX);
        else if (v > DIV_W'(CELL_MAX)) return 9'(CELL_MAX);
        else                           return v[8:0];
    endfunction

    t_state r_state, n_state;
    logic   r_go, n_go;

    // latched input item
    logic [13:0] r_rx, n_rx;
    logic [13:0] r_ry, n_ry;
    logic [31:0] r_now, n_now;

    // tracking state
    logic signed [15:0] r_avg_x, n_avg_x, r_avg_y, n_avg_y;
    logic signed [15:0] r_off_x, n_off_x, r_off_y, n_off_y;
    logic               r_rel, n_rel;
    logic               r_drag, n_drag;
    logic [31:0]        r_lift, n_lift;

    // working values
    logic signed [25:0] r_cal, n_cal;
    logic signed [17:0] r_x, n_x, r_y, n_y;
    logic               r_btn, n_btn;
    logic signed [8:0]  r_col, n_col;

    // finished result, held until the output register takes it
    logic [55:0] r_stage, n_stage;

    // output register
    logic        r_m_valid, n_m_valid;
    logic [55:0] r_m_data, n_m_data;

    logic               sel_y;
    logic signed [14:0] cal_d;
    logic signed [15:0] cal_span;
    logic [31:0]        gap;
    logic               press, bounce;
    logic signed [15:0] d_off_x, d_off_y, d_avg_x, d_avg_y;
    logic signed [17:0] d_x, d_y;

    always_comb begin
        sel_y    = (r_state == ST_CALY);
        cal_d    = sel_y ? ($signed({1'b0, r_ry}) - $signed({1'b0, cfg.cal_y_low}))
                         : ($signed({1'b0, r_rx}) - $signed({1'b0, cfg.cal_x_low}));
        cal_span = sel_y ? ($signed({2'b0, cfg.cal_y_high}) - $signed({2'b0, cfg.cal_y_low}))
                         : ($signed({2'b0, cfg.cal_x_high}) - $signed({2'b0, cfg.cal_x_low}));
        gap      = r_now - r_lift;
        press    = (gap > 32'(cfg.debounce_ms)) && (gap < 32'(cfg.tap_window_ms));
        bounce   = (gap <= 32'(cfg.debounce_ms));
    end

    // divider operands per step
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (r_state)
            ST_CALX, ST_CALY: begin
                div_req.num = (DIV_W'(cal_d) <<< 9) + (DIV_W'(cal_d) <<< 8);
                div_req.den = cal_span;
            end
            ST_SCLX, ST_SCLY: begin
                div_req.num = DIV_W'(r_cal) * DIV_W'(POS_MAX);
                div_req.den = DEN_W'(SCALE_DIV);
            end
            ST_SMX: begin
                div_req.num = DIV_W'(r_avg_x) * DIV_W'(AVG_WEIGHT) + DIV_W'(r_x);
                div_req.den = DEN_W'(AVG_WEIGHT + 1);
            end
            ST_SMY: begin
                div_req.num = DIV_W'(r_avg_y) * DIV_W'(AVG_WEIGHT) + DIV_W'(r_y);
                div_req.den = DEN_W'(AVG_WEIGHT + 1);
            end
            ST_CELX: begin
                div_req.num = DIV_W'(r_avg_x) * DIV_W'($signed({1'b0, cfg.screen_cols}));
                div_req.den = DEN_W'(CELL_DIV);
            end
            ST_CELY: begin
                div_req.num = DIV_W'(r_avg_y) * DIV_W'($signed({1'b0, cfg.screen_rows}));
                div_req.den = DEN_W'(CELL_DIV);
            end
            default: begin
                div_req.num = '0;
            end
        endcase
        if (r_go && r_state != ST_IDLE && r_state != ST_DECIDE && r_state != ST_OUT) begin
            div_req.start = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_go      = 1'b0;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_now     = r_now;
        n_avg_x   = r_avg_x;
        n_avg_y   = r_avg_y;
        n_off_x   = r_off_x;
        n_off_y   = r_off_y;
        n_rel     = r_rel;
        n_drag    = r_drag;
        n_lift    = r_lift;
        n_cal     = r_cal;
        n_x       = r_x;
        n_y       = r_y;
        n_btn     = r_btn;
        n_col     = r_col;
        n_stage   = r_stage;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;
        d_off_x   = r_off_x;
        d_off_y   = r_off_y;
        d_avg_x   = r_avg_x;
        d_avg_y   = r_avg_y;
        d_x       = r_x;
        d_y       = r_y;
        o_s_axis_tready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_rx  = i_s_axis_tdata[13:0];
                    n_ry  = i_s_axis_tdata[27:14];
                    n_now = i_s_axis_tdata[59:28];
                    n_go  = 1'b1;
                    if (i_s_axis_tuser) begin
                        n_state = ST_CALX;
                    end else begin
                        // finger-up: remember the lift point and time
                        n_off_x = r_avg_x;
                        n_off_y = r_avg_y;
                        n_lift  = i_s_axis_tdata[59:28];
                        n_rel   = 1'b1;
                        n_btn   = 1'b0;
                        n_state = ST_CELX;
                    end
                end
            end
            ST_CALX, ST_CALY: begin
                if (div_rsp.done) begin
                    n_cal   = 26'(DIV_W'(CAL_BASE) + div_rsp.quo);
                    n_go    = 1'b1;
                    n_state = (r_state == ST_CALX) ? ST_SCLX : ST_SCLY;
                end
            end
            ST_SCLX: begin
                if (div_rsp.done) begin
                    n_x     = clamp_pos(div_rsp.quo);
                    n_go    = 1'b1;
                    n_state = ST_CALY;
                end
            end
            ST_SCLY: begin
                if (div_rsp.done) begin
                    n_y     = clamp_pos(DIV_W'(POS_MAX) - div_rsp.quo);
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_btn = 1'b0;
                if (r_rel && press) begin
                    // tap: press at the lift point and start a drag
                    n_rel   = 1'b0;
                    n_drag  = 1'b1;
                    n_btn   = 1'b1;
                    n_avg_x = r_off_x;
                    n_avg_y = r_off_y;
                    n_off_x = sat16(DIV_W'(r_off_x) - DIV_W'(r_x));
                    n_off_y = sat16(DIV_W'(r_off_y) - DIV_W'(r_y));
                    n_go    = 1'b1;
                    n_state = ST_CELX;
                end else begin
                    if (r_rel) begin
                        n_rel = 1'b0;
                        if (bounce) begin
                            d_off_x = '0;
                            d_off_y = '0;
                        end else begin
                            n_drag  = 1'b0;
                            d_avg_x = 16'(r_x);
                            d_avg_y = 16'(r_y);
                        end
                    end
                    if (n_drag) begin
                        d_x   = 18'(19'(r_x) + 19'(d_off_x));
                        d_y   = 18'(19'(r_y) + 19'(d_off_y));
                        n_btn = 1'b1;
                    end
                    n_off_x = d_off_x;
                    n_off_y = d_off_y;
                    n_avg_x = d_avg_x;
                    n_avg_y = d_avg_y;
                    n_x     = d_x;
                    n_y     = d_y;
                    n_go    = 1'b1;
                    n_state = ST_SMX;
                end
            end
            ST_SMX: begin
                if (div_rsp.done) begin
                    n_avg_x = sat16(div_rsp.quo);
                    n_go    = 1'b1;
                    n_state = ST_SMY;
                end
            end
            ST_SMY: begin
                if (div_rsp.done) begin
                    n_avg_y = sat16(div_rsp.quo);
                    n_go    = 1'b1;
                    n_state = ST_CELX;
                end
            end
            ST_CELX: begin
                if (div_rsp.done) begin
                    n_col   = sat_cell(div_rsp.quo);
                    n_go    = 1'b1;
                    n_state = ST_CELY;
                end
            end
            ST_CELY: begin
                if (div_rsp.done) begin
                    n_stage = {5'd0, sat_cell(div_rsp.quo), r_col, r_avg_y, r_avg_x, r_btn};
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_stage;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_go      <= 1'b0;
            r_avg_x   <= '0;
            r_avg_y   <= '0;
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_rel     <= 1'b0;
            r_drag    <= 1'b0;
            r_lift    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_go      <= n_go;
            r_avg_x   <= n_avg_x;
            r_avg_y   <= n_avg_y;
            r_off_x   <= n_off_x;
            r_off_y   <= n_off_y;
            r_rel     <= n_rel;
            r_drag    <= n_drag;
            r_lift    <= n_lift;
            r_m_valid <= n_m_valid;
        end
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_now    <= n_now;
        r_cal    <= n_cal;
        r_x      <= n_x;
        r_y      <= n_y;
        r_btn    <= n_btn;
        r_col    <= n_col;
        r_stage  <= n_stage;
        r_m_data <= n_m_data;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `ASSERT_IMPL(a_out_from_out_state, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(r_state == ST_OUT))

endmodule
